/* hw/rtl/stsc_pkg.sv */
// Shared types, token codes and keyword table for the source token scanner.
package stsc_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned KeywordChars     = 8;
  localparam int unsigned NumKeywords      = 17;
  localparam int unsigned MaxRes           = 3;
  localparam int unsigned FifoDepth        = 8;

  typedef enum logic [5:0] {
    TOK_STAR_EQ, TOK_STAR, TOK_SLASH_EQ, TOK_SLASH, TOK_INC, TOK_PLUS_EQ, TOK_PLUS,
    TOK_DEC, TOK_MINUS_EQ, TOK_MINUS, TOK_GE, TOK_GT, TOK_LE, TOK_LT, TOK_NE, TOK_EQ,
    TOK_ASSIGN, TOK_DOT, TOK_COMMA, TOK_LPAREN, TOK_RPAREN, TOK_LBRACK, TOK_RBRACK,
    TOK_LBRACE, TOK_RBRACE, TOK_UNDERSCORE, TOK_SEMI, TOK_NUMBER, TOK_IDENT,
    TOK_KW_THEN, TOK_KW_DO, TOK_KW_UNTIL, TOK_KW_VOID, TOK_KW_OD, TOK_KW_FI,
    TOK_KW_ELSE, TOK_KW_LET, TOK_KW_CALL, TOK_KW_IF, TOK_KW_WHILE, TOK_KW_REPEAT,
    TOK_KW_RETURN, TOK_KW_VAR, TOK_KW_ARRAY, TOK_KW_FUNCTION, TOK_KW_MAIN,
    TOK_END, TOK_ERROR
  } token_e;

  typedef struct packed {
    token_e             token;
    logic signed [31:0] value;
    logic [15:0]        lexeme_len;
    logic [31:0]        start_pos;
    logic [23:0]        line;
    logic               final_res;
  } res_t;

  // keyword text, first character in the low byte, zero padded
  localparam logic [KeywordChars*8-1:0] KwWord [NumKeywords] = '{
    64'h0000_0000_6E65_6874,  // then
    64'h0000_0000_0000_6F64,  // do
    64'h0000_006C_6974_6E75,  // until
    64'h0000_0000_6469_6F76,  // void
    64'h0000_0000_0000_646F,  // od
    64'h0000_0000_0000_6966,  // fi
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0000_0074_656C,  // let
    64'h0000_0000_6C6C_6163,  // call
    64'h0000_0000_0000_6669,  // if
    64'h0000_0065_6C69_6877,  // while
    64'h0000_7461_6570_6572,  // repeat
    64'h0000_6E72_7574_6572,  // return
    64'h0000_0000_0072_6176,  // var
    64'h0000_0079_6172_7261,  // array
    64'h6E6F_6974_636E_7566,  // function
    64'h0000_0000_6E69_616D   // main
  };

  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd4, 4'd2, 4'd5, 4'd4, 4'd2, 4'd2, 4'd4, 4'd3, 4'd4,
    4'd2, 4'd5, 4'd6, 4'd6, 4'd3, 4'd5, 4'd8, 4'd4
  };

  function automatic token_e word_token(input logic [KeywordChars*8-1:0] wbuf,
                                        input logic [15:0] len);
    token_e tok;
    logic   hit;
    tok = TOK_IDENT;
    hit = 1'b0;
    for (int k = 0; k < NumKeywords; k++) begin
      if (!hit && len == 16'(KwLen[k]) && wbuf == KwWord[k]) begin
        tok = token_e'(6'(TOK_KW_THEN) + 6'(k));
        hit = 1'b1;
      end
    end
    return tok;
  endfunction

endpackage

/* hw/rtl/stsc_lexer.sv */
// Scanner state and per-character token logic, up to three result words per step.
module stsc_lexer
  import stsc_pkg::*;
#(
  parameter int unsigned ValueBits = ValueBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              ch_i,
  input  logic                    eot_i,
  output logic [1:0]              push_cnt_o,
  output res_t [MaxRes-1:0]       push_res_o
);

  localparam int unsigned WordBits = KeywordChars * 8;
  localparam int unsigned PosBits  = $clog2(KeywordChars);
  localparam int unsigned ExtBits  = ((ValueBits > 32) ? ValueBits : 32) + 1;
  localparam logic [ValueBits-1:0] PosLim = {1'b0, {(ValueBits-1){1'b1}}};
  localparam logic [ValueBits-1:0] NegLim = {1'b1, {(ValueBits-1){1'b0}}};

  localparam logic [7:0] ChTab = 8'h09, ChNl = 8'h0A, ChCr = 8'h0D, ChSp = 8'h20;
  localparam logic [7:0] ChBang = 8'h21, ChLParen = 8'h28, ChRParen = 8'h29;
  localparam logic [7:0] ChStar = 8'h2A, ChPlus = 8'h2B, ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D, ChDot = 8'h2E, ChSlash = 8'h2F;
  localparam logic [7:0] ChZero = 8'h30, ChNine = 8'h39, ChColon = 8'h3A;
  localparam logic [7:0] ChSemi = 8'h3B, ChLt = 8'h3C, ChEq = 8'h3D, ChGt = 8'h3E;
  localparam logic [7:0] ChUpA = 8'h41, ChUpZ = 8'h5A, ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D, ChUscore = 8'h5F, ChLoA = 8'h61;
  localparam logic [7:0] ChLoZ = 8'h7A, ChLBrace = 8'h7B, ChRBrace = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_OP, MODE_NUM, MODE_WORD, MODE_COMMENT
  } mode_e;

  typedef struct packed {
    logic   hit;
    token_e tok;
  } op_t;

  function automatic op_t single_op(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      ChDot:    r.tok = TOK_DOT;
      ChComma:  r.tok = TOK_COMMA;
      ChLParen: r.tok = TOK_LPAREN;
      ChRParen: r.tok = TOK_RPAREN;
      ChLBrack: r.tok = TOK_LBRACK;
      ChRBrack: r.tok = TOK_RBRACK;
      ChLBrace: r.tok = TOK_LBRACE;
      ChRBrace: r.tok = TOK_RBRACE;
      ChUscore: r.tok = TOK_UNDERSCORE;
      ChSemi:   r.tok = TOK_SEMI;
      default: begin
        r.hit = 1'b0;
        r.tok = TOK_ERROR;
      end
    endcase
    return r;
  endfunction

  function automatic op_t with_eq(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      ChStar:  r.tok = TOK_STAR_EQ;
      ChSlash: r.tok = TOK_SLASH_EQ;
      ChPlus:  r.tok = TOK_PLUS_EQ;
      ChMinus: r.tok = TOK_MINUS_EQ;
      ChGt:    r.tok = TOK_GE;
      ChLt:    r.tok = TOK_LE;
      ChBang:  r.tok = TOK_NE;
      ChEq:    r.tok = TOK_EQ;
      ChColon: r.tok = TOK_ASSIGN;
      default: begin
        r.hit = 1'b0;
        r.tok = TOK_ERROR;
      end
    endcase
    return r;
  endfunction

  function automatic op_t lone_op(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      ChStar:  r.tok = TOK_STAR;
      ChSlash: r.tok = TOK_SLASH;
      ChPlus:  r.tok = TOK_PLUS;
      ChMinus: r.tok = TOK_MINUS;
      ChGt:    r.tok = TOK_GT;
      ChLt:    r.tok = TOK_LT;
      default: begin
        r.hit = 1'b0;
        r.tok = TOK_ERROR;
      end
    endcase
    return r;
  endfunction

  // acc*10 + d, clamped to the signed range limit
  function automatic logic [ValueBits-1:0] add_digit(input logic [ValueBits-1:0] acc,
                                                     input logic neg,
                                                     input logic [3:0] d);
    logic [ValueBits+3:0] prod;
    logic [ValueBits-1:0] lim;
    lim  = neg ? NegLim : PosLim;
    prod = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {{ValueBits{1'b0}}, d};
    if (prod > {4'b0000, lim}) begin
      return lim;
    end
    return prod[ValueBits-1:0];
  endfunction

  function automatic logic signed [31:0] num_value(input logic [ValueBits-1:0] acc,
                                                   input logic neg);
    logic [ExtBits-1:0] e;
    e = ExtBits'(acc);
    if (neg) begin
      e = -e;
    end
    return e[31:0];
  endfunction

  function automatic res_t mk_res(input token_e tok, input logic signed [31:0] val,
                                  input logic [15:0] len, input logic [31:0] start,
                                  input logic [23:0] ln, input logic fin);
    res_t r;
    r.token      = tok;
    r.value      = val;
    r.lexeme_len = len;
    r.start_pos  = start;
    r.line       = ln;
    r.final_res  = fin;
    return r;
  endfunction

  mode_e                mode_q, mode_d;
  logic [7:0]           held_q, held_d;
  logic [WordBits-1:0]  wbuf_q, wbuf_d;
  logic [15:0]          wlen_q, wlen_d;
  logic [31:0]          tstart_q, tstart_d;
  logic [31:0]          cpos_q, cpos_d;
  logic [ValueBits-1:0] acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic [23:0]          line_q, line_d;
  logic                 stuck_q, stuck_d;

  mode_e                mode_f;
  logic [7:0]           held_f;
  logic [WordBits-1:0]  wbuf_f;
  logic [15:0]          wlen_f;
  logic [31:0]          tstart_f;
  logic [ValueBits-1:0] acc_f;
  logic                 neg_f;
  logic [23:0]          line_f;

  logic        is_digit, is_letter, is_word, is_blank, is_nl;
  logic [15:0] wlen_inc;
  logic [23:0] line_inc;
  logic [31:0] cpos_inc;
  logic        go_idle, err_feed, err_tail;
  op_t         sop, weq_c, weq_h, lone_h, lone_f;
  res_t        res_a, res_b, res_c, res_d;
  logic        v_a, v_b, v_c, v_d;
  res_t [2:0]  cand;
  logic [2:0]  cand_v;
  logic [1:0]  idx;

  assign is_digit  = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_letter = ((ch_i >= ChUpA) && (ch_i <= ChUpZ)) ||
                     ((ch_i >= ChLoA) && (ch_i <= ChLoZ));
  assign is_word   = is_digit || is_letter || (ch_i == ChUscore);
  assign is_blank  = (ch_i == ChSp) || (ch_i == ChTab) || (ch_i == ChCr);
  assign is_nl     = (ch_i == ChNl);
  assign wlen_inc  = (wlen_q == 16'hFFFF) ? wlen_q : wlen_q + 16'd1;
  assign line_inc  = (line_q == 24'hFFFFFF) ? line_q : line_q + 24'd1;
  assign cpos_inc  = (cpos_q == 32'hFFFF_FFFF) ? cpos_q : cpos_q + 32'd1;
  assign sop       = single_op(ch_i);
  assign weq_c     = with_eq(ch_i);
  assign weq_h     = with_eq(held_q);
  assign lone_h    = lone_op(held_q);

  always_comb begin
    mode_f   = mode_q;
    held_f   = held_q;
    wbuf_f   = wbuf_q;
    wlen_f   = wlen_q;
    tstart_f = tstart_q;
    acc_f    = acc_q;
    neg_f    = neg_q;
    line_f   = line_q;
    go_idle  = 1'b0;
    err_feed = 1'b0;
    v_a      = 1'b0;
    v_b      = 1'b0;
    res_a    = mk_res(TOK_ERROR, '0, 16'd1, tstart_q, line_q, 1'b1);
    res_b    = mk_res(TOK_ERROR, '0, 16'd1, cpos_q, line_q, 1'b1);

    case (mode_q)
      MODE_COMMENT: begin
        if (is_nl) begin
          line_f = line_inc;
          mode_f = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_digit) begin
          acc_f  = add_digit(acc_q, neg_q, ch_i[3:0]);
          wlen_f = wlen_inc;
        end else begin
          v_a     = 1'b1;
          res_a   = mk_res(TOK_NUMBER, num_value(acc_q, neg_q), wlen_q, tstart_q,
                           line_q, 1'b0);
          go_idle = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_word) begin
          if (wlen_q < 16'(KeywordChars)) begin
            wbuf_f = wbuf_q | (WordBits'(ch_i) << {wlen_q[PosBits-1:0], 3'b000});
          end
          wlen_f = wlen_inc;
        end else begin
          v_a     = 1'b1;
          res_a   = mk_res(word_token(wbuf_q, wlen_q), '0, wlen_q, tstart_q, line_q, 1'b0);
          go_idle = 1'b1;
        end
      end
      MODE_OP: begin
        mode_f = MODE_IDLE;
        if (ch_i == ChEq && weq_h.hit) begin
          v_a   = 1'b1;
          res_a = mk_res(weq_h.tok, '0, 16'd2, tstart_q, line_q, 1'b0);
        end else if (held_q == ChPlus && ch_i == ChPlus) begin
          v_a   = 1'b1;
          res_a = mk_res(TOK_INC, '0, 16'd2, tstart_q, line_q, 1'b0);
        end else if (held_q == ChMinus && ch_i == ChMinus) begin
          v_a   = 1'b1;
          res_a = mk_res(TOK_DEC, '0, 16'd2, tstart_q, line_q, 1'b0);
        end else if (held_q == ChSlash && ch_i == ChSlash) begin
          mode_f = MODE_COMMENT;
        end else if (held_q == ChMinus && is_digit) begin
          mode_f = MODE_NUM;
          neg_f  = 1'b1;
          acc_f  = add_digit('0, 1'b1, ch_i[3:0]);
          wlen_f = 16'd2;
        end else if (lone_h.hit) begin
          v_a     = 1'b1;
          res_a   = mk_res(lone_h.tok, '0, 16'd1, tstart_q, line_q, 1'b0);
          go_idle = 1'b1;
        end else begin
          v_a      = 1'b1;
          err_feed = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      mode_f = MODE_IDLE;
      if (is_blank) begin
        mode_f = MODE_IDLE;
      end else if (is_nl) begin
        line_f = line_inc;
      end else if (sop.hit) begin
        v_b   = 1'b1;
        res_b = mk_res(sop.tok, '0, 16'd1, cpos_q, line_q, 1'b0);
      end else if (weq_c.hit) begin
        held_f   = ch_i;
        tstart_f = cpos_q;
        mode_f   = MODE_OP;
      end else if (is_digit) begin
        mode_f   = MODE_NUM;
        neg_f    = 1'b0;
        acc_f    = add_digit('0, 1'b0, ch_i[3:0]);
        wlen_f   = 16'd1;
        tstart_f = cpos_q;
      end else if (is_letter) begin
        mode_f   = MODE_WORD;
        wbuf_f   = WordBits'(ch_i);
        wlen_f   = 16'd1;
        tstart_f = cpos_q;
      end else begin
        v_b      = 1'b1;
        err_feed = 1'b1;
      end
    end
  end

  // flush at end of text
  assign lone_f = lone_op(held_f);

  always_comb begin
    v_c      = 1'b0;
    err_tail = 1'b0;
    res_c    = mk_res(TOK_ERROR, '0, 16'd1, tstart_f, line_f, 1'b1);
    if (eot_i && !err_feed) begin
      case (mode_f)
        MODE_NUM: begin
          v_c   = 1'b1;
          res_c = mk_res(TOK_NUMBER, num_value(acc_f, neg_f), wlen_f, tstart_f, line_f, 1'b0);
        end
        MODE_WORD: begin
          v_c   = 1'b1;
          res_c = mk_res(word_token(wbuf_f, wlen_f), '0, wlen_f, tstart_f, line_f, 1'b0);
        end
        MODE_OP: begin
          v_c = 1'b1;
          if (lone_f.hit) begin
            res_c = mk_res(lone_f.tok, '0, 16'd1, tstart_f, line_f, 1'b0);
          end else begin
            err_tail = 1'b1;
          end
        end
        default: begin
          v_c = 1'b0;
        end
      endcase
    end
    v_d   = eot_i && !err_feed && !err_tail;
    res_d = mk_res(TOK_END, '0, 16'd0, cpos_inc, line_f, 1'b1);
  end

  always_comb begin
    cand[0]    = res_a;
    cand[1]    = v_b ? res_b : res_c;
    cand[2]    = res_d;
    cand_v     = {v_d, v_b || v_c, v_a};
    push_res_o = '0;
    idx        = 2'd0;
    for (int j = 0; j < 3; j++) begin
      if (cand_v[j]) begin
        push_res_o[idx] = cand[j];
        idx             = idx + 2'd1;
      end
    end
    push_cnt_o = (step_i && !stuck_q) ? idx : 2'd0;
  end

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    wbuf_d   = wbuf_q;
    wlen_d   = wlen_q;
    tstart_d = tstart_q;
    cpos_d   = cpos_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    line_d   = line_q;
    stuck_d  = stuck_q;
    if (step_i) begin
      if (eot_i) begin
        mode_d   = MODE_IDLE;
        held_d   = '0;
        wbuf_d   = '0;
        wlen_d   = '0;
        tstart_d = '0;
        cpos_d   = '0;
        acc_d    = '0;
        neg_d    = 1'b0;
        line_d   = 24'd1;
        stuck_d  = 1'b0;
      end else if (!stuck_q) begin
        mode_d   = mode_f;
        held_d   = held_f;
        wbuf_d   = wbuf_f;
        wlen_d   = wlen_f;
        tstart_d = tstart_f;
        cpos_d   = cpos_inc;
        acc_d    = acc_f;
        neg_d    = neg_f;
        line_d   = line_f;
        stuck_d  = err_feed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      held_q   <= '0;
      wbuf_q   <= '0;
      wlen_q   <= '0;
      tstart_q <= '0;
      cpos_q   <= '0;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      line_q   <= 24'd1;
      stuck_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      wbuf_q   <= wbuf_d;
      wlen_q   <= wlen_d;
      tstart_q <= tstart_d;
      cpos_q   <= cpos_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      line_q   <= line_d;
      stuck_q  <= stuck_d;
    end
  end

`ifndef ASSERT_OFF
  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eot_i |=> mode_q == MODE_IDLE && cpos_q == '0 && line_q == 24'd1 && !stuck_q)
    else $error("scanner state not cleared after end of text");

  a_stuck_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |-> push_cnt_o == 2'd0)
    else $error("output while silenced after error");

  a_stuck_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stuck_q) |-> $past(push_cnt_o != 2'd0))
    else $error("silenced without an error word");
`endif

endmodule

/* hw/rtl/stsc_res_fifo.sv */
// Result word queue: up to three writes per cycle, one read.
module stsc_res_fifo
  import stsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  res_t [MaxRes-1:0] push_res_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output res_t              out_res_o
);

  localparam int unsigned AddrBits = $clog2(FifoDepth);
  localparam int unsigned CntBits  = AddrBits + 1;

  res_t                mem [FifoDepth];
  logic [AddrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= CntBits'(FifoDepth - MaxRes));

  assign wr_ptr_d = wr_ptr_q + AddrBits'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + AddrBits'(pop);
  assign count_d  = count_q + CntBits'(push_cnt_i) - CntBits'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (push_cnt_i > 2'(i)) begin
        mem[wr_ptr_q + AddrBits'(i)] <= push_res_i[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> CntBits'(FifoDepth) - count_q >= CntBits'(push_cnt_i))
    else $error("result queue overrun");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (wr_ptr_q == rd_ptr_q) || count_q == CntBits'(FifoDepth))
    else $error("result queue count and pointers disagree");
`endif

endmodule

/* hw/rtl/source_token_scanner_core.sv */
// A character is registered at the input, scanned, and its result words are queued before they leave.
// Throughput: one character per cycle while the result queue holds five words or fewer;
// one result word leaves per cycle while out_stall_i is low.
// Reset (rst_ni low, asynchronous): scanner idle, position 0, line 1, queue empty.
// Every end-of-text character returns the scanner, but not the queue, to that same state.
// Top level of the source token scanner.
module source_token_scanner_core
  import stsc_pkg::*;
#(
  parameter int unsigned ValueBits = ValueBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               end_of_text_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         token_o,
  output logic signed [31:0] value_o,
  output logic [15:0]        lexeme_len_o,
  output logic [31:0]        start_pos_o,
  output logic [23:0]        line_o,
  output logic               final_res_o
);

  logic              in_valid_q;
  logic [7:0]        ch_q;
  logic              eot_q;
  logic              room;
  logic              step;
  logic              take;
  logic [1:0]        push_cnt;
  res_t [MaxRes-1:0] push_res;
  res_t              out_res;

  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ch_q  <= ch_i;
      eot_q <= end_of_text_i;
    end
  end

  stsc_lexer #(
    .ValueBits(ValueBits)
  ) u_lexer (
    .clk_i,
    .rst_ni,
    .step_i    (step),
    .ch_i      (ch_q),
    .eot_i     (eot_q),
    .push_cnt_o(push_cnt),
    .push_res_o(push_res)
  );

  stsc_res_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_cnt_i (push_cnt),
    .push_res_i (push_res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res)
  );

  assign token_o      = 6'(out_res.token);
  assign value_o      = out_res.value;
  assign lexeme_len_o = out_res.lexeme_len;
  assign start_pos_o  = out_res.start_pos;
  assign line_o       = out_res.line;
  assign final_res_o  = out_res.final_res;

endmodule
